// File: design/four_level_page_walker_top_assert.svh
// Assertion macros for the page walker.
// All properties are clocked on clk and switched off while rst_n is low.
`ifndef FOUR_LEVEL_PAGE_WALKER_TOP_ASSERT_SVH
`define FOUR_LEVEL_PAGE_WALKER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPLW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page walker check failed");

// Consequent must hold in the cycle after the antecedent.
`define FPLW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page walker check failed");

`endif

// File: design/fplw_pkg.sv
package fplw_pkg;

    localparam int VA_BITS    = 48;
    localparam int PA_BITS    = 52;
    localparam int PAGE_SHIFT = 12;
    localparam int INDEX_BITS = 9;
    localparam int FRAME_W    = PA_BITS - PAGE_SHIFT;

    localparam logic CMD_START    = 1'b0;
    localparam logic CMD_RESPONSE = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
    localparam logic [1:0] ST_NOT_USER    = 2'd2;

    localparam logic [2:0] LEVEL_NONE = 3'd0;
    localparam logic [2:0] LEVEL_LEAF = 3'd1;
    localparam logic [2:0] LEVEL_PD   = 3'd2;
    localparam logic [2:0] LEVEL_PDPT = 3'd3;
    localparam logic [2:0] LEVEL_TOP  = 3'd4;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_USER    = 2;

    typedef logic [VA_BITS-1:0]    va_t;
    typedef logic [PA_BITS-1:0]    pa_t;
    typedef logic [FRAME_W-1:0]    frame_t;
    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [63:0]           entry_t;

    // 9-bit table index for a level; anything outside 2..4 is treated as the leaf level
    function automatic index_t va_index(input va_t va, input logic [2:0] level);
        index_t idx;
        case (level)
            LEVEL_TOP:  idx = va[47:39];
            LEVEL_PDPT: idx = va[38:30];
            LEVEL_PD:   idx = va[29:21];
            default:    idx = va[20:12];
        endcase
        return idx;
    endfunction

    // frame base is page aligned, so index times 8 simply fills the low 12 bits
    function automatic pa_t entry_addr(input frame_t frame, input index_t idx);
        return {frame, idx, 3'b000};
    endfunction

endpackage

// File: design/fplw_if.sv
interface fplw_cmd_if;
    import fplw_pkg::*;

    logic   valid;
    logic   ready;
    logic   command;
    va_t    virt_addr;
    entry_t read_data;

    modport source (output valid, output command, output virt_addr, output read_data,
                    input ready);
    modport sink   (input valid, input command, input virt_addr, input read_data,
                    output ready);
endinterface

interface fplw_rsp_if;
    import fplw_pkg::*;

    logic       valid;
    logic       ready;
    logic       kind;
    pa_t        read_addr;
    pa_t        phys_addr;
    logic [1:0] status;
    logic [2:0] missing_level;

    modport source (output valid, output kind, output read_addr, output phys_addr,
                    output status, output missing_level, input ready);
    modport sink   (input valid, input kind, input read_addr, input phys_addr,
                    input status, input missing_level, output ready);
endinterface

interface fplw_cfg_if;
    import fplw_pkg::*;

    logic valid;
    logic ready;
    pa_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/four_level_page_walker_top.sv
// channel | dir | payload                                            | item
// --------+-----+----------------------------------------------------+--------------------------
// cmd     | in  | command, virt_addr, read_data                      | start or table entry
// rsp     | out | kind, read_addr, phys_addr, status, missing_level  | entry read or final result
// cfg     | in  | data (table_root)                                  | root table base
//
// Each cmd item is decoded in the cycle it is accepted; its result (if any) appears on rsp
// from the next cycle, held in a single output register.
// cmd.ready is high whenever that register is empty or being drained: one item per cycle.
// Ignored items (start while walking, entry while idle) are accepted and give no result.
// cfg.ready is always high. rst_n clears the walk state, the root and the output valid.
`include "four_level_page_walker_top_assert.svh"

module four_level_page_walker_top (
    input  logic           clk,
    input  logic           rst_n,
    fplw_cmd_if.sink       cmd,
    fplw_rsp_if.source     rsp,
    fplw_cfg_if.sink       cfg
);
    import fplw_pkg::*;

    pa_t        root_reg;
    logic       busy_reg,  busy_next;
    logic [2:0] level_reg, level_next;
    va_t        va_reg,    va_next;
    frame_t     base_reg,  base_next;

    logic       out_valid_reg;
    logic       kind_reg,    kind_next;
    pa_t        raddr_reg,   raddr_next;
    pa_t        paddr_reg,   paddr_next;
    logic [1:0] status_reg,  status_next;
    logic [2:0] missing_reg, missing_next;

    logic       res_valid;
    logic       accept;
    logic [2:0] level_cur;
    frame_t     entry_frame;

    assign cmd.ready   = !out_valid_reg || rsp.ready;
    assign cfg.ready   = 1'b1;
    assign accept      = cmd.valid && cmd.ready;
    assign entry_frame = cmd.read_data[PA_BITS-1:PAGE_SHIFT];

    // while walking the level is always 1..4; anything else reads as the leaf
    assign level_cur = (level_reg >= LEVEL_LEAF && level_reg <= LEVEL_TOP) ? level_reg
                                                                          : LEVEL_LEAF;

    always_comb
    begin
        busy_next    = busy_reg;
        level_next   = level_reg;
        va_next      = va_reg;
        base_next    = base_reg;
        res_valid    = 1'b0;
        kind_next    = KIND_READ;
        raddr_next   = '0;
        paddr_next   = '0;
        status_next  = ST_OK;
        missing_next = LEVEL_NONE;

        if (cmd.command == CMD_START)
        begin
            if (!busy_reg)
            begin
                va_next    = cmd.virt_addr;
                base_next  = root_reg[PA_BITS-1:PAGE_SHIFT];
                level_next = LEVEL_TOP;
                busy_next  = 1'b1;
                res_valid  = 1'b1;
                raddr_next = entry_addr(root_reg[PA_BITS-1:PAGE_SHIFT],
                                        va_index(cmd.virt_addr, LEVEL_TOP));
            end
        end
        else if (busy_reg)
        begin
            res_valid = 1'b1;
            if (!cmd.read_data[BIT_PRESENT])
            begin
                busy_next    = 1'b0;
                level_next   = LEVEL_NONE;
                kind_next    = KIND_DONE;
                status_next  = ST_NOT_PRESENT;
                missing_next = level_cur;
            end
            else if (level_cur == LEVEL_LEAF)
            begin
                busy_next  = 1'b0;
                level_next = LEVEL_NONE;
                kind_next  = KIND_DONE;
                if (!cmd.read_data[BIT_USER])
                    status_next = ST_NOT_USER;
                else
                    paddr_next = {entry_frame, va_reg[PAGE_SHIFT-1:0]};
            end
            else
            begin
                base_next  = entry_frame;
                level_next = level_cur - 3'd1;
                raddr_next = entry_addr(entry_frame, va_index(va_reg, level_cur - 3'd1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg  <= '0;
            busy_reg  <= 1'b0;
            level_reg <= LEVEL_NONE;
            va_reg    <= '0;
            base_reg  <= '0;
        end
        else
        begin
            if (cfg.valid)
                root_reg <= cfg.data;
            if (accept)
            begin
                busy_reg  <= busy_next;
                level_reg <= level_next;
                va_reg    <= va_next;
                base_reg  <= base_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && res_valid)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            kind_reg    <= kind_next;
            raddr_reg   <= raddr_next;
            paddr_reg   <= paddr_next;
            status_reg  <= status_next;
            missing_reg <= missing_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = kind_reg;
    assign rsp.read_addr     = raddr_reg;
    assign rsp.phys_addr     = paddr_reg;
    assign rsp.status        = status_reg;
    assign rsp.missing_level = missing_reg;

    // base_reg tracks the current table frame; it must agree with the last read issued
    `FPLW_ASSERT_NOW(a_level_range, busy_reg, level_reg >= LEVEL_LEAF && level_reg <= LEVEL_TOP)
    `FPLW_ASSERT_NOW(a_idle_level, !busy_reg, level_reg == LEVEL_NONE)
    `FPLW_ASSERT_NEXT(a_start_issues, accept && cmd.command == CMD_START && !busy_reg,
        busy_reg && level_reg == LEVEL_TOP && rsp.valid && rsp.kind == KIND_READ)
    `FPLW_ASSERT_NEXT(a_miss_ends, accept && cmd.command == CMD_RESPONSE && busy_reg &&
        !cmd.read_data[BIT_PRESENT],
        !busy_reg && rsp.valid && rsp.kind == KIND_DONE && rsp.status == ST_NOT_PRESENT)
    `FPLW_ASSERT_NOW(a_read_base, rsp.valid && rsp.kind == KIND_READ && busy_reg,
        rsp.read_addr[PA_BITS-1:PAGE_SHIFT] == base_reg)

endmodule

// File: verif/tb_top.sv
module tb_top;
    import fplw_pkg::*;

    typedef struct packed {
        logic       kind;
        pa_t        read_addr;
        pa_t        phys_addr;
        logic [1:0] status;
        logic [2:0] missing_level;
    } walk_result_t;

    logic clk;
    logic rst_n;

    fplw_cmd_if cmd_ch();
    fplw_rsp_if rsp_ch();
    fplw_cfg_if cfg_ch();

    four_level_page_walker_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // walker state as the testbench sees it
    pa_t        root_reg;
    logic       walk_busy;
    logic [2:0] walk_lvl;
    va_t        walk_va;
    pa_t        walk_base;

    walk_result_t walk_outputs_due[$];
    int           walk_items_predicted;
    int           mismatch_count;

    bit src_jitter;
    bit rcv_jitter;
    int stall_cycles;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

    // address of the entry for one level: frame of the table plus 8 times its index
    function automatic pa_t entry_loc(input pa_t base, input va_t va, input logic [2:0] lvl);
        int         shift;
        logic [8:0] idx;
        shift = PAGE_SHIFT + INDEX_BITS * (lvl - 1);
        idx   = 9'(va >> shift);
        return {base[PA_BITS-1:PAGE_SHIFT], 12'h000} + {idx, 3'b000};
    endfunction

    function automatic entry_t rand_entry(input bit present, input bit user);
        entry_t e;
        e = {$urandom, $urandom};
        e[BIT_PRESENT] = present;
        e[BIT_USER]    = user;
        return e;
    endfunction

    task automatic predict_walk(input logic c, input va_t va, input entry_t ent);
        walk_result_t r;
        logic [2:0]   lvl;
        r = '0;
        if (c == CMD_START) begin
            if (walk_busy)
                return;
            walk_va   = va;
            walk_base = {root_reg[PA_BITS-1:PAGE_SHIFT], 12'h000};
            walk_lvl  = LEVEL_TOP;
            walk_busy = 1'b1;
            r.kind      = KIND_READ;
            r.read_addr = entry_loc(walk_base, walk_va, walk_lvl);
        end
        else begin
            if (!walk_busy)
                return;
            lvl = (walk_lvl >= LEVEL_LEAF && walk_lvl <= LEVEL_TOP) ? walk_lvl : LEVEL_LEAF;
            if (!ent[BIT_PRESENT]) begin
                walk_busy       = 1'b0;
                walk_lvl        = LEVEL_NONE;
                r.kind          = KIND_DONE;
                r.status        = ST_NOT_PRESENT;
                r.missing_level = lvl;
            end
            else if (lvl == LEVEL_LEAF) begin
                walk_busy = 1'b0;
                walk_lvl  = LEVEL_NONE;
                r.kind    = KIND_DONE;
                if (!ent[BIT_USER])
                    r.status = ST_NOT_USER;
                else
                    r.phys_addr = {ent[PA_BITS-1:PAGE_SHIFT], walk_va[PAGE_SHIFT-1:0]};
            end
            else begin
                walk_base   = {ent[PA_BITS-1:PAGE_SHIFT], 12'h000};
                walk_lvl    = lvl - 3'd1;
                r.kind      = KIND_READ;
                r.read_addr = entry_loc(walk_base, walk_va, walk_lvl);
            end
        end
        walk_outputs_due.push_back(r);
        walk_items_predicted++;
    endtask

    // called and returns at a falling edge; valid stays high for a following item
    task automatic send_item(input logic c, input va_t va, input entry_t ent);
        if (src_jitter && $urandom_range(0, 9) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= c;
        cmd_ch.virt_addr <= va;
        cmd_ch.read_data <= ent;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        predict_walk(c, va, ent);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (walk_outputs_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_root(input pa_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        root_reg = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // mostly complete walks with random entries, plus stray and abandoned items
    task automatic random_walk();
        va_t    va;
        entry_t ent;
        int     lvl;
        bit     present;
        bit     user;
        va = va_t'({$urandom, $urandom});
        if ($urandom_range(0, 9) == 0)
            send_item(CMD_RESPONSE, va,
                      rand_entry(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        send_item(CMD_START, va, {$urandom, $urandom});
        for (lvl = LEVEL_TOP; lvl >= LEVEL_LEAF; lvl--) begin
            if ($urandom_range(0, 29) == 0)
                return;
            if ($urandom_range(0, 9) == 0)
                send_item(CMD_START, va_t'({$urandom, $urandom}), {$urandom, $urandom});
            present = $urandom_range(0, 9) != 0;
            user    = (lvl != LEVEL_LEAF) ? 1'($urandom_range(0, 1))
                                          : ($urandom_range(0, 4) != 0);
            ent     = rand_entry(present, user);
            send_item(CMD_RESPONSE, va_t'({$urandom, $urandom}), ent);
            if (!present)
                return;
        end
    endtask

    task automatic test_directed();
        int lvl;
        src_jitter = 1'b1;
        rcv_jitter = 1'b1;
        write_root('1);
        // entry while idle is dropped
        send_item(CMD_RESPONSE, '0, '1);
        send_item(CMD_START, '1, '0);
        repeat (4) send_item(CMD_RESPONSE, '0, '1);
        // start during a walk is dropped; leaf without user bit
        send_item(CMD_START, '0, '1);
        send_item(CMD_START, '1, '0);
        repeat (4) send_item(CMD_RESPONSE, '1, entry_t'(1) << BIT_PRESENT);
        // missing entry at every level
        for (lvl = LEVEL_TOP; lvl >= LEVEL_LEAF; lvl--) begin
            send_item(CMD_START, va_t'({$urandom, $urandom}), '0);
            repeat (LEVEL_TOP - lvl) send_item(CMD_RESPONSE, '0, '1);
            send_item(CMD_RESPONSE, '1, '0);
        end
        wait_drained();
        write_root('0);
    endtask

    // root written between the first read and the rest of the walk
    task automatic test_root_mid_walk();
        send_item(CMD_START, va_t'({$urandom, $urandom}), '0);
        wait_drained();
        write_root(pa_t'({$urandom, $urandom}));
        repeat (3) send_item(CMD_RESPONSE, '0, rand_entry(1'b1, 1'b0));
        send_item(CMD_RESPONSE, '0, rand_entry(1'b1, 1'b1));
        wait_drained();
    endtask

    task automatic test_backpressure();
        int target;
        src_jitter   = 1'b0;
        rcv_jitter   = 1'b0;
        stall_cycles = 150;
        target = walk_items_predicted + 30;
        while (walk_items_predicted < target) random_walk();
        wait_drained();
    endtask

    task automatic test_random();
        pa_t roots[4];
        int  target;
        int  i;
        roots[0] = pa_t'({$urandom, $urandom});
        roots[1] = '1;
        roots[2] = '0;
        roots[3] = pa_t'({$urandom, $urandom});
        src_jitter = 1'b1;
        rcv_jitter = 1'b1;
        for (i = 0; i < 4; i++) begin
            write_root(roots[i]);
            target = walk_items_predicted + 210;
            while (walk_items_predicted < target) random_walk();
            wait_drained();
        end
        // closing stretch at full rate
        src_jitter = 1'b0;
        rcv_jitter = 1'b0;
        write_root(pa_t'({$urandom, $urandom}));
        target = walk_items_predicted + 60;
        while (walk_items_predicted < target) random_walk();
        wait_drained();
    endtask

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall_cycles) @(negedge clk);
                stall_cycles = 0;
                rsp_ch.ready <= 1'b1;
            end
            else if (rcv_jitter && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic flag_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    initial begin
        walk_result_t due;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (walk_outputs_due.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual kind %0h addr %0h",
                             $time, rsp_ch.kind, rsp_ch.read_addr);
                    mismatch_count++;
                end
                else begin
                    due = walk_outputs_due.pop_front();
                    flag_field("kind", 64'(due.kind), 64'(rsp_ch.kind));
                    flag_field("read_addr", 64'(due.read_addr), 64'(rsp_ch.read_addr));
                    flag_field("phys_addr", 64'(due.phys_addr), 64'(rsp_ch.phys_addr));
                    flag_field("status", 64'(due.status), 64'(rsp_ch.status));
                    flag_field("missing_level", 64'(due.missing_level),
                               64'(rsp_ch.missing_level));
                end
            end
        end
    end

    initial begin
        rst_n                = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.command       = CMD_START;
        cmd_ch.virt_addr     = '0;
        cmd_ch.read_data     = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;
        root_reg             = '0;
        walk_busy            = 1'b0;
        walk_lvl             = LEVEL_NONE;
        walk_va              = '0;
        walk_base            = '0;
        walk_items_predicted = 0;
        mismatch_count       = 0;
        src_jitter           = 1'b0;
        rcv_jitter           = 1'b0;
        stall_cycles         = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_root_mid_walk();
        test_backpressure();
        test_random();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && walk_outputs_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
